// ===== rtl/e2q_pkg.sv =====
package e2q_pkg;

    localparam int unsigned QW = 32;
    localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;
    localparam logic [31:0] QONE = 32'h4000_0000;
    localparam int unsigned NSTEP = 8;
    localparam int unsigned LANE_LAT = 2 * NSTEP + 3;
    localparam int unsigned MERGE_LAT = 2;

    typedef logic [QW-1:0] q30_t;
    typedef logic signed [QW:0] sq30_t;

    typedef struct packed {
        q30_t cmag;
        q30_t smag;
        logic sneg;
    } trig_t;

    function automatic q30_t umulq(input q30_t a, input q30_t b);
        logic [63:0] p;
        begin
            p = 64'(a) * 64'(b) + 64'h2000_0000;
            umulq = q30_t'(p >> 30);
        end
    endfunction

    function automatic logic [7:0] cos_den(input logic [3:0] j);
        begin
            cos_den = 8'((2 * j - 1) * (2 * j));
        end
    endfunction

    function automatic logic [7:0] sin_den(input logic [3:0] j);
        begin
            sin_den = 8'((2 * j) * (2 * j + 1));
        end
    endfunction

    // ceil(2^(32 + clog2(d)) / d): exact floor division of any 32-bit numerator
    function automatic logic [32:0] den_recip(input logic [7:0] d);
        logic [63:0] num;
        begin
            num = (64'd1 << (32 + $clog2(d))) + 64'(d) - 64'd1;
            den_recip = 33'(num / 64'(d));
        end
    endfunction

endpackage

// ===== rtl/e2q_lane.sv =====
module e2q_lane #(
    parameter int ANGLE_BITS = 16
) (
    input  logic clk,
    input  logic en,
    input  logic [ANGLE_BITS-1:0] angle,
    output e2q_pkg::trig_t trig
);
    import e2q_pkg::*;

    logic [31:0] a32;
    logic neg;
    logic [31:0] m;
    logic [63:0] rp;
    q30_t r0_reg, r1_reg, x1_reg;
    logic n0_reg, n1_reg;
    q30_t tc_out, ts_out, r_out, s;
    logic n_out;

    assign a32 = 32'({angle, {(32 - ANGLE_BITS + 1){1'b0}}} >> 1);
    assign neg = a32[31];
    assign m = neg ? 32'((33'h1_0000_0000 - 33'(a32) + 33'd1) >> 1) : (a32 >> 1);
    assign rp = 64'(m) * 64'(PI_Q30) + 64'(QONE);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg <= q30_t'(rp >> 31);
            n0_reg <= neg;
            r1_reg <= r0_reg;
            n1_reg <= n0_reg;
            x1_reg <= umulq(r0_reg, r0_reg);
        end
    end

    // one series term per two stages: multiply, then divide by reciprocal
    genvar gi;
    generate
        for (gi = 0; gi < NSTEP; gi++)
        begin : g_step
            localparam logic [7:0] DC = cos_den(4'(NSTEP - gi));
            localparam logic [7:0] DS = sin_den(4'(NSTEP - gi));
            localparam int KC = 32 + $clog2(DC);
            localparam int KS = 32 + $clog2(DS);
            localparam logic [32:0] RC = den_recip(DC);
            localparam logic [32:0] RS = den_recip(DS);

            q30_t x_in, tc_in, ts_in, r_in;
            logic n_in;
            logic [32:0] nc_reg, ns_reg;
            q30_t ra_reg, rb_reg, tc_reg, ts_reg;
            logic na_reg, nb_reg;
            logic [65:0] pc, ps;
            q30_t qc, qs;

            if (gi == 0)
            begin : g_src
                assign x_in = x1_reg;
                assign tc_in = QONE;
                assign ts_in = QONE;
                assign r_in = r1_reg;
                assign n_in = n1_reg;
            end
            else
            begin : g_src
                assign x_in = g_step[gi-1].g_xcarry.xb_reg;
                assign tc_in = g_step[gi-1].tc_reg;
                assign ts_in = g_step[gi-1].ts_reg;
                assign r_in = g_step[gi-1].rb_reg;
                assign n_in = g_step[gi-1].nb_reg;
            end

            if (gi < NSTEP - 1)
            begin : g_xcarry
                q30_t xa_reg, xb_reg;
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        xa_reg <= x_in;
                        xb_reg <= xa_reg;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    nc_reg <= {1'b0, umulq(x_in, tc_in)} + 33'(DC >> 1);
                    ns_reg <= {1'b0, umulq(x_in, ts_in)} + 33'(DS >> 1);
                    ra_reg <= r_in;
                    na_reg <= n_in;
                end
            end

            assign pc = 66'(nc_reg) * 66'(RC);
            assign ps = 66'(ns_reg) * 66'(RS);
            assign qc = q30_t'(pc >> KC);
            assign qs = q30_t'(ps >> KS);

            // hold sine at one in the first step, its series is one term shorter
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tc_reg <= (qc >= QONE) ? '0 : QONE - qc;
                    ts_reg <= (gi == 0) ? QONE : ((qs >= QONE) ? '0 : QONE - qs);
                    rb_reg <= ra_reg;
                    nb_reg <= na_reg;
                end
            end
        end
    endgenerate

    assign tc_out = g_step[NSTEP-1].tc_reg;
    assign ts_out = g_step[NSTEP-1].ts_reg;
    assign r_out = g_step[NSTEP-1].rb_reg;
    assign n_out = g_step[NSTEP-1].nb_reg;

    assign s = umulq(r_out, ts_out);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trig.cmag <= tc_out;
            trig.smag <= (s > QONE) ? QONE : s;
            trig.sneg <= n_out;
        end
    end
endmodule

// ===== rtl/e2q_merge.sv =====
module e2q_merge #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic clk,
    input  logic en0,
    input  logic en1,
    input  e2q_pkg::trig_t ty,
    input  e2q_pkg::trig_t tp,
    input  e2q_pkg::trig_t tr,
    output logic [4*COMPONENT_BITS-1:0] quat
);
    import e2q_pkg::*;

    localparam int FRAC = COMPONENT_BITS - 1;

    typedef struct packed {
        q30_t mag;
        logic neg;
    } sm_t;

    sm_t pa_reg [4];
    logic ny_reg;
    q30_t ycm_reg, ysm_reg;
    sq30_t comp [4];

    function automatic sm_t smul(input q30_t a, input logic na, input q30_t b, input logic nb);
        sm_t v;
        begin
            v.mag = umulq(a, b);
            v.neg = na ^ nb;
            smul = v;
        end
    endfunction

    function automatic sq30_t sgn(input sm_t v);
        begin
            sgn = v.neg ? -sq30_t'({1'b0, v.mag}) : sq30_t'({1'b0, v.mag});
        end
    endfunction

    function automatic logic [COMPONENT_BITS-1:0] to_out(input sq30_t v);
        logic neg;
        logic [QW+COMPONENT_BITS:0] mag;
        logic [QW+COMPONENT_BITS:0] lim;
        begin
            neg = v[QW];
            mag = (QW + COMPONENT_BITS + 1)'(neg ? -v : v);
            if (FRAC < 30)
                mag = (mag + ((QW + COMPONENT_BITS + 1)'(1) << (29 - FRAC))) >> (30 - FRAC);
            else
                mag = mag << (FRAC - 30);
            lim = (QW + COMPONENT_BITS + 1)'(1) << FRAC;
            if (!neg && mag > lim - 1)
                mag = lim - 1;
            if (neg && mag > lim)
                mag = lim;
            to_out = neg ? COMPONENT_BITS'(-mag) : COMPONENT_BITS'(mag);
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            pa_reg[0] <= smul(tr.cmag, 1'b0, tp.cmag, 1'b0);
            pa_reg[1] <= smul(tr.smag, tr.sneg, tp.smag, tp.sneg);
            pa_reg[2] <= smul(tr.smag, tr.sneg, tp.cmag, 1'b0);
            pa_reg[3] <= smul(tr.cmag, 1'b0, tp.smag, tp.sneg);
            ycm_reg <= ty.cmag;
            ysm_reg <= ty.smag;
            ny_reg <= ty.sneg;
        end
    end

    always_comb
    begin
        comp[0] = sgn(smul(pa_reg[0].mag, pa_reg[0].neg, ycm_reg, 1'b0))
                + sgn(smul(pa_reg[1].mag, pa_reg[1].neg, ysm_reg, ny_reg));
        comp[1] = sgn(smul(pa_reg[2].mag, pa_reg[2].neg, ycm_reg, 1'b0))
                - sgn(smul(pa_reg[3].mag, pa_reg[3].neg, ysm_reg, ny_reg));
        comp[2] = sgn(smul(pa_reg[3].mag, pa_reg[3].neg, ycm_reg, 1'b0))
                + sgn(smul(pa_reg[2].mag, pa_reg[2].neg, ysm_reg, ny_reg));
        comp[3] = sgn(smul(pa_reg[0].mag, pa_reg[0].neg, ysm_reg, ny_reg))
                - sgn(smul(pa_reg[1].mag, pa_reg[1].neg, ycm_reg, 1'b0));
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            quat <= {to_out(comp[3]), to_out(comp[2]), to_out(comp[1]), to_out(comp[0])};
        end
    end
endmodule

// ===== rtl/euler_to_quaternion.sv =====
// Throughput: one word per cycle when not stalled.
// Three trig lanes feed one product merge.
// The pipeline advances as a whole; a stall at the output holds every stage.
// Reset: rst_n asynchronous, active low, clears the stage valid bits only.
module euler_to_quaternion #(
    parameter int ANGLE_BITS = 16,
    parameter int COMPONENT_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // yaw_angle, pitch_angle, roll_angle
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [((4*COMPONENT_BITS+7)/8)*8-1:0] m_axis_tdata
);
    import e2q_pkg::*;

    localparam int NST = int'(LANE_LAT + MERGE_LAT);

    logic [NST-1:0] vld_reg;
    logic adv;
    trig_t ty, tp, tr;
    logic [4*COMPONENT_BITS-1:0] quat;

    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata = ($bits(m_axis_tdata))'(quat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
    end

    e2q_lane #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .clk(clk), .en(adv),
        .angle(s_axis_tdata[ANGLE_BITS-1:0]), .trig(ty));
    e2q_lane #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .clk(clk), .en(adv),
        .angle(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .trig(tp));
    e2q_lane #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .clk(clk), .en(adv),
        .angle(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]), .trig(tr));

    e2q_merge #(.COMPONENT_BITS(COMPONENT_BITS)) u_merge (
        .clk(clk), .en0(adv), .en1(adv),
        .ty(ty), .tp(tp), .tr(tr), .quat(quat));

`ifndef NO_ASSERTIONS
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted word not tracked");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved during stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");
`endif
endmodule
